[rtl/bvg_pkg.sv]
// ----------------------------------------------------------------------------
// bvg_pkg
// shared types and constants of the battery voltage filter and charge gauge
// ----------------------------------------------------------------------------
package bvg_pkg;

  localparam int ADC_W      = 12;
  localparam int MV_W       = 13;
  localparam int PCT_W      = 7;
  localparam int SCALE_W    = 2 * ADC_W;
  localparam int DIV_W      = 2 * ADC_W;
  localparam int DIV_CNT_W  = 5;
  localparam int CHG_NUM_W  = 12;
  localparam int CURVE_LEN  = 21;
  localparam int SEG_W      = 5;

  localparam logic [ADC_W-1:0] FS_RESET    = 12'd3100;
  localparam logic [MV_W-1:0]  MV_FULL     = 13'd4200;
  localparam logic [MV_W-1:0]  MV_EMPTY    = 13'd3000;
  localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;

  localparam logic REG_CAL = 1'b0;
  localparam logic REG_FS  = 1'b1;

  localparam logic [MV_W-1:0] CURVE_MV [CURVE_LEN] = '{
    13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980, 13'd3950,
    13'd3910, 13'd3870, 13'd3850, 13'd3840, 13'd3820, 13'd3800, 13'd3790,
    13'd3770, 13'd3750, 13'd3730, 13'd3710, 13'd3690, 13'd3610, 13'd3000
  };

  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_LEN] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
    7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
    7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
  };

  typedef enum logic [1:0] {
    OP_MEAN,
    OP_CHARGE
  } div_op_e;

  typedef struct packed {
    logic    load_pin;
    logic    ring_push;
    logic    div_start;
    div_op_e div_op;
    logic    load_mean;
    logic    load_base;
    logic    load_out;
  } bvg_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } bvg_status_t;

endpackage

[rtl/bvg_div.sv]
// ----------------------------------------------------------------------------
// bvg_div
// restoring divider, one quotient bit per cycle, shared by all divisions
// ----------------------------------------------------------------------------
module bvg_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bvg_pkg::DIV_W-1:0]      dividend_i,
  input  logic [bvg_pkg::ADC_W-1:0]      divisor_i,
  input  logic [bvg_pkg::DIV_CNT_W-1:0]  nbits_i,
  output logic                           done_o,
  output logic [bvg_pkg::DIV_W-1:0]      quotient_o
);
  import bvg_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     dq_q, dq_d;
  logic [ADC_W-1:0]     rem_q, rem_d;
  logic [ADC_W-1:0]     div_q;
  logic [ADC_W:0]       shifted;
  logic [ADC_W+1:0]     trial;
  logic                 fits;

  always_comb begin
    shifted = {rem_q, dq_q[DIV_W-1]};
    trial   = {1'b0, shifted} - {2'b00, div_q};
    fits    = ~trial[ADC_W+1];
    rem_d   = fits ? trial[ADC_W-1:0] : shifted[ADC_W-1:0];
    dq_d    = {dq_q[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= nbits_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

[rtl/bvg_dpath.sv]
// ----------------------------------------------------------------------------
// bvg_dpath
// datapath: sample scaling, averaging ring, curve lookup and output register
// ----------------------------------------------------------------------------
module bvg_dpath #(
  parameter int AVG_DEPTH = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bvg_pkg::ADC_W-1:0]   adc_sample_i,
  input  logic                        cfg_calibrated_i,
  input  logic [bvg_pkg::ADC_W-1:0]   cfg_full_scale_i,
  input  bvg_pkg::bvg_cmd_t           cmd_i,
  output bvg_pkg::bvg_status_t        status_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [bvg_pkg::MV_W-1:0]    filtered_mv_o,
  output logic [bvg_pkg::PCT_W-1:0]   charge_percent_o
);
  import bvg_pkg::*;

  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W  = $clog2(AVG_DEPTH * 6142 + 1);

  logic [ADC_W-1:0]  pin_q;
  logic [MV_W-1:0]   ring_q [AVG_DEPTH];
  logic [SLOT_W-1:0] slot_q;
  logic              full_q;
  logic [SUM_W-1:0]  sum_q;
  logic [MV_W-1:0]   mean_q;
  logic [PCT_W-1:0]  base_q;
  logic              out_vld_q;
  logic [MV_W-1:0]   out_mv_q;
  logic [PCT_W-1:0]  out_pct_q;

  logic [SCALE_W-1:0] scale_prod;
  logic [SCALE_W-1:0] scale_sum;
  logic [ADC_W-1:0]   pin_scaled;

  logic [ADC_W+1:0]  pin_x3;
  logic [MV_W-1:0]   batt_mv;
  logic [SUM_W-1:0]  sum_d;
  logic [CNT_W-1:0]  count;

  logic [SEG_W-1:0]       seg;
  logic [SEG_W-1:0]       seg_lo;
  logic [MV_W-1:0]        vl;
  logic [MV_W-1:0]        diff;
  logic [PCT_W-1:0]       rise;
  logic [MV_W+PCT_W-1:0]  prod;
  logic [CHG_NUM_W-1:0]   chg_num;
  logic [ADC_W-1:0]       chg_span;
  logic [PCT_W-1:0]       chg_base;

  logic [DIV_W-1:0]     div_dividend;
  logic [ADC_W-1:0]     div_divisor;
  logic [DIV_CNT_W-1:0] div_nbits;
  logic                 div_done;
  logic [DIV_W-1:0]     quotient;

  // raw code to pin millivolts, divide by 4095 as (x + (x >> 12) + 1) >> 12
  always_comb begin
    scale_prod = SCALE_W'(adc_sample_i) * SCALE_W'(cfg_full_scale_i);
    scale_sum  = scale_prod + (scale_prod >> ADC_W) + SCALE_W'(1);
    pin_scaled = scale_sum[SCALE_W-1:ADC_W];
  end

  // battery side of the 1.5 divider
  always_comb begin
    pin_x3  = {2'b00, pin_q} + {1'b0, pin_q, 1'b0};
    batt_mv = pin_x3[MV_W:1];
    sum_d   = sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(batt_mv);
    count   = full_q ? CNT_W'(AVG_DEPTH) : CNT_W'(slot_q);
  end

  // discharge curve segment
  always_comb begin
    seg = '0;
    for (int k = CURVE_LEN - 2; k >= 0; k--) begin
      if (mean_q >= CURVE_MV[k+1]) begin
        seg = SEG_W'(k);
      end
    end
    seg_lo   = seg + SEG_W'(1);
    vl       = CURVE_MV[seg_lo];
    diff     = mean_q - vl;
    rise     = CURVE_PCT[seg] - CURVE_PCT[seg_lo];
    prod     = (MV_W+PCT_W)'(diff) * (MV_W+PCT_W)'(rise);
    if (mean_q >= CURVE_MV[0]) begin
      chg_base = PCT_FULL;
      chg_num  = '0;
      chg_span = ADC_W'(1);
    end else if (mean_q <= CURVE_MV[CURVE_LEN-1]) begin
      chg_base = '0;
      chg_num  = '0;
      chg_span = ADC_W'(1);
    end else begin
      chg_base = CURVE_PCT[seg_lo];
      chg_num  = prod[CHG_NUM_W-1:0];
      chg_span = ADC_W'(CURVE_MV[seg] - vl);
    end
  end

  // divider operands
  always_comb begin
    case (cmd_i.div_op)
      OP_MEAN: begin
        div_dividend = DIV_W'(sum_q) << (DIV_W - SUM_W);
        div_divisor  = ADC_W'(count);
        div_nbits    = DIV_CNT_W'(SUM_W);
      end
      OP_CHARGE: begin
        div_dividend = DIV_W'(chg_num) << (DIV_W - CHG_NUM_W);
        div_divisor  = chg_span;
        div_nbits    = DIV_CNT_W'(CHG_NUM_W);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = ADC_W'(1);
        div_nbits    = DIV_CNT_W'(1);
      end
    endcase
  end

  bvg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .nbits_i    (div_nbits),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // averaging ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      slot_q <= '0;
      full_q <= 1'b0;
      sum_q  <= '0;
    end else if (cmd_i.ring_push) begin
      ring_q[slot_q] <= batt_mv;
      sum_q          <= sum_d;
      if (slot_q == SLOT_W'(AVG_DEPTH - 1)) begin
        slot_q <= '0;
        full_q <= 1'b1;
      end else begin
        slot_q <= slot_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pin) begin
      pin_q <= cfg_calibrated_i ? adc_sample_i : pin_scaled;
    end
    if (cmd_i.load_mean) begin
      mean_q <= quotient[MV_W-1:0];
    end
    if (cmd_i.load_base) begin
      base_q <= chg_base;
    end
    if (cmd_i.load_out) begin
      out_mv_q  <= mean_q;
      out_pct_q <= base_q + quotient[PCT_W-1:0];
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign status_o.div_done   = div_done;
  assign status_o.out_free   = ~out_vld_q | ~out_stall_i;

  assign out_valid_o      = out_vld_q;
  assign filtered_mv_o    = out_mv_q;
  assign charge_percent_o = out_pct_q;

endmodule

[rtl/bvg_ctrl.sv]
// ----------------------------------------------------------------------------
// bvg_ctrl
// controller: sequences scaling, ring update and the two gauge divisions
// ----------------------------------------------------------------------------
module bvg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bvg_pkg::bvg_status_t  status_i,
  output bvg_pkg::bvg_cmd_t     cmd_o
);
  import bvg_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RING    = 3'd2;
  localparam logic [2:0] S_MEAN_GO = 3'd3;
  localparam logic [2:0] S_MEAN    = 3'd4;
  localparam logic [2:0] S_CHG_GO  = 3'd5;
  localparam logic [2:0] S_CHG     = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_pin = 1'b1;
          state_d        = S_RING;
        end
      end
      S_RING: begin
        cmd_o.ring_push = 1'b1;
        state_d         = S_MEAN_GO;
      end
      S_MEAN_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = OP_MEAN;
        state_d         = S_MEAN;
      end
      S_MEAN: begin
        if (status_i.div_done) begin
          cmd_o.load_mean = 1'b1;
          state_d         = S_CHG_GO;
        end
      end
      S_CHG_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = OP_CHARGE;
        cmd_o.load_base = 1'b1;
        state_d         = S_CHG;
      end
      S_CHG: begin
        if (status_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[rtl/battery_voltage_filter_and_gauge.sv]
// ----------------------------------------------------------------------------
// battery_voltage_filter_and_gauge
// converter sample to averaged battery millivolts and Li-ion state of charge
// ----------------------------------------------------------------------------
// One word in gives one word out. The result is loaded into the output
// register once the mean and curve divisions have finished, in raw and
// calibrated mode alike; the next sample is accepted in the cycle after
// that load, even while the result still waits there. A result left
// waiting holds back the following load, and with it the sample after
// that. A single divider produces one quotient bit per cycle and performs,
// in turn, the mean over the filled ring entries (S steps, with S the width
// of the running sum, 16 at a depth of 10) and the curve interpolation (12
// steps); raw codes are scaled by a multiply and a shift-based divide by
// 4095 in the accept cycle. Configuration registers sit at byte address 0
// (calibrated mode) and 4 (raw full-scale millivolts).
// ----------------------------------------------------------------------------
module battery_voltage_filter_and_gauge #(
  parameter int AVG_DEPTH = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bvg_pkg::ADC_W-1:0]  adc_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bvg_pkg::MV_W-1:0]   filtered_mv_o,
  output logic [bvg_pkg::PCT_W-1:0]  charge_percent_o
);
  import bvg_pkg::*;

  logic             cal_q;
  logic [ADC_W-1:0] fs_q;
  logic             cfg_wr;
  bvg_cmd_t         cmd;
  bvg_status_t      status;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= 1'b0;
      fs_q  <= FS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CAL: cal_q <= pwdata[0];
        REG_FS:  fs_q  <= pwdata[ADC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CAL: prdata = {31'd0, cal_q};
      REG_FS:  prdata = {{(32-ADC_W){1'b0}}, fs_q};
      default: prdata = '0;
    endcase
  end

  bvg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bvg_dpath #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adc_sample_i     (adc_sample_i),
    .cfg_calibrated_i (cal_q),
    .cfg_full_scale_i (fs_q),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .filtered_mv_o    (filtered_mv_o),
    .charge_percent_o (charge_percent_o)
  );

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("block took a second word while one was in flight");

  a_pct_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (charge_percent_o <= PCT_FULL)
  ) else $error("charge above full scale");

  a_empty_cell: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (filtered_mv_o <= MV_EMPTY)) |-> (charge_percent_o == '0)
  ) else $error("nonzero charge at or below empty voltage");

  a_full_cell: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (filtered_mv_o >= MV_FULL)) |-> (charge_percent_o == PCT_FULL)
  ) else $error("charge not full at or above full voltage");

endmodule

[tb/sv/bvg_gauge_checker.sv]
// ----------------------------------------------------------------------------
// bvg_gauge_checker
// Watches the register port and both word channels of the battery gauge.
// Mirrors the register writes and predicts each result from the accepted
// samples: full-scale scaling, divider ratio, ring mean, discharge curve.
// Compares every result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bvg_gauge_checker #(
  parameter int AVG_DEPTH = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [2:0]                 paddr_i,
  input  logic [31:0]                pwdata_i,
  input  logic                       pready_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [bvg_pkg::ADC_W-1:0]  adc_sample_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [bvg_pkg::MV_W-1:0]   filtered_mv_i,
  input  logic [bvg_pkg::PCT_W-1:0]  charge_percent_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o,
  output int unsigned                checked_o
);

  localparam int CURVE_N = 21;
  localparam int unsigned KNEE_MV [CURVE_N] = '{
    4200, 4150, 4110, 4080, 4020, 3980, 3950, 3910, 3870, 3850, 3840,
    3820, 3800, 3790, 3770, 3750, 3730, 3710, 3690, 3610, 3000
  };
  localparam int unsigned KNEE_PCT [CURVE_N] = '{
    100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
    45, 40, 35, 30, 25, 20, 15, 10, 5, 0
  };

  typedef struct packed {
    logic [bvg_pkg::MV_W-1:0]  mv;
    logic [bvg_pkg::PCT_W-1:0] pct;
  } gauge_word_t;

  logic                      cal_mode;
  logic [bvg_pkg::ADC_W-1:0] full_scale;
  int unsigned               ring [AVG_DEPTH];
  int unsigned               slot;
  logic                      filled;
  int unsigned               ring_sum;
  gauge_word_t               gauge_words_due [$];
  gauge_word_t               due_word;

  function automatic logic [bvg_pkg::PCT_W-1:0] charge_of(input int unsigned mv);
    int unsigned k;
    int unsigned lo;
    int unsigned pct;
    logic        found;
    pct   = 0;
    found = 1'b0;
    if (mv >= KNEE_MV[0]) begin
      pct = KNEE_PCT[0];
    end else if (mv > KNEE_MV[CURVE_N-1]) begin
      for (k = 0; k + 1 < CURVE_N; k++) begin
        if (!found && mv >= KNEE_MV[k+1]) begin
          found = 1'b1;
          lo    = KNEE_MV[k+1];
          pct   = KNEE_PCT[k+1]
                + ((mv - lo) * (KNEE_PCT[k] - KNEE_PCT[k+1])) / (KNEE_MV[k] - lo);
        end
      end
    end
    return pct[bvg_pkg::PCT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t bvg_gauge_checker: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic predict_gauge_word(input logic [bvg_pkg::ADC_W-1:0] sample);
    int unsigned pin;
    int unsigned batt;
    int unsigned count;
    int unsigned mean;
    gauge_word_t w;
    if (cal_mode) pin = sample;
    else pin = (int'(sample) * int'(full_scale)) / 4095;
    batt = ((pin * 3) >> 1) & 32'h1FFF;
    ring_sum = ring_sum - ring[slot] + batt;
    ring[slot] = batt;
    slot++;
    if (slot >= AVG_DEPTH) begin
      slot   = 0;
      filled = 1'b1;
    end
    count = filled ? AVG_DEPTH : slot;
    mean  = ring_sum / count;
    w.mv  = mean[bvg_pkg::MV_W-1:0];
    w.pct = charge_of(mean & 32'h1FFF);
    gauge_words_due.push_back(w);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_mode   = 1'b0;
      full_scale = bvg_pkg::FS_RESET;
      for (int i = 0; i < AVG_DEPTH; i++) ring[i] = 0;
      slot         = 0;
      filled       = 1'b0;
      ring_sum     = 0;
      gauge_words_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == bvg_pkg::REG_CAL) cal_mode = pwdata_i[0];
        else full_scale = pwdata_i[bvg_pkg::ADC_W-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (gauge_words_due.size() == 0) begin
          report_mismatch("result word with no sample pending");
        end else begin
          due_word = gauge_words_due.pop_front();
          if (filtered_mv_i !== due_word.mv)
            report_mismatch($sformatf("filtered_mv %0d, expected %0d",
                                      filtered_mv_i, due_word.mv));
          if (charge_percent_i !== due_word.pct)
            report_mismatch($sformatf("charge_percent %0d, expected %0d (mv %0d)",
                                      charge_percent_i, due_word.pct, due_word.mv));
        end
      end
      if (in_valid_i && !in_stall_i) predict_gauge_word(adc_sample_i);
      pending_o = gauge_words_due.size();
    end
  end

endmodule

[tb/sv/tb_battery_voltage_filter_and_gauge.sv]
// ----------------------------------------------------------------------------
// tb_battery_voltage_filter_and_gauge
// Drives samples and register writes into the battery gauge under several
// idling patterns and gives the verdict. A directed set covers the field
// extremes, zero full scale, calibrated samples, curve ends and the partly
// filled ring; random phases then sweep levels across the discharge curve.
// ----------------------------------------------------------------------------
module tb_battery_voltage_filter_and_gauge;

  localparam logic [2:0] ADDR_CAL     = {bvg_pkg::REG_CAL, 2'b00};
  localparam logic [2:0] ADDR_FS      = {bvg_pkg::REG_FS, 2'b00};
  localparam int         QUIET_LIMIT  = 3000;
  localparam int         RAND_PHASES  = 8;
  localparam int         PHASE_WORDS  = 106;

  logic                       clk_i;
  logic                       rst_ni       = 1'b0;
  logic                       psel         = 1'b0;
  logic                       penable      = 1'b0;
  logic                       pwrite       = 1'b0;
  logic [2:0]                 paddr        = '0;
  logic [31:0]                pwdata       = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic [bvg_pkg::ADC_W-1:0]  adc_sample_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic [bvg_pkg::MV_W-1:0]   filtered_mv_o;
  logic [bvg_pkg::PCT_W-1:0]  charge_percent_o;

  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned words_checked;
  int unsigned words_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned battery_level = 3600;
  logic        cur_cal       = 1'b0;
  int unsigned cur_fs        = 3100;

  battery_voltage_filter_and_gauge uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .adc_sample_i     (adc_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_mv_o    (filtered_mv_o),
    .charge_percent_o (charge_percent_o)
  );

  bvg_gauge_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .adc_sample_i     (adc_sample_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_mv_i    (filtered_mv_o),
    .charge_percent_i (charge_percent_o),
    .fail_count_o     (fail_count),
    .pending_o        (words_pending),
    .checked_o        (words_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // nothing moving on any port for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("timeout with %0d words pending", words_pending);
        $display("tb_battery_voltage_filter_and_gauge: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (words_pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_mode(input logic cal, input int unsigned fs, input logic junk);
    logic [31:0] upper;
    upper = junk ? $urandom : 32'h0;
    drain();
    write_reg(ADDR_CAL, {upper[31:1], cal});
    write_reg(ADDR_FS, {upper[31:12], fs[11:0]});
    cur_cal = cal;
    cur_fs  = fs;
  endtask

  task automatic push_sample(input logic [bvg_pkg::ADC_W-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= sample;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    words_sent++;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 80; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 80; end
      default: begin send_idle_pct = 10; stall_pct = 10; end
    endcase
  endtask

  // mostly a slowly moving battery level so the mean walks along the curve
  function automatic logic [bvg_pkg::ADC_W-1:0] pick_sample();
    int unsigned r;
    int unsigned k;
    int unsigned pin;
    int unsigned code;
    r = $urandom_range(99);
    k = $urandom_range(11);
    if (r < 10) begin
      case ($urandom_range(3))
        0: code = 0;
        1: code = 4095;
        2: code = 1 << k;
        default: code = 4095 ^ (1 << k);
      endcase
    end else if (r < 30 || (!cur_cal && cur_fs == 0)) begin
      code = $urandom_range(4095);
    end else begin
      if ($urandom_range(15) == 0) battery_level = $urandom_range(4350, 2900);
      pin  = ((battery_level + $urandom_range(40)) - 20) * 2 / 3;
      code = cur_cal ? pin : (pin * 4095) / cur_fs;
      if (code > 4095) code = 4095;
    end
    return code[bvg_pkg::ADC_W-1:0];
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // raw mode at the reset full scale, ring still filling
    set_mode(1'b0, 3100, 1'b0);
    push_sample(12'd0);
    push_sample(12'd4095);
    push_sample(12'd3699);
    push_sample(12'd1);
    push_sample(12'd2048);
    push_sample(12'hAAA);
    push_sample(12'h555);
    // zero full scale
    set_mode(1'b0, 0, 1'b0);
    push_sample(12'd4095);
    push_sample(12'd1234);
    set_mode(1'b0, 4095, 1'b0);
    push_sample(12'd4095);
    push_sample(12'd0);
    // calibrated samples, curve ends and knees
    set_mode(1'b1, 4095, 1'b0);
    push_sample(12'd4095);
    push_sample(12'd2800);
    push_sample(12'd2000);
    push_sample(12'd2001);
    push_sample(12'd2734);
    push_sample(12'd2567);
    push_sample(12'd2540);
    push_sample(12'd0);
    push_sample(12'd2100);
    push_sample(12'd2500);

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: set_mode(1'b1, $urandom_range(4095), 1'b1);
        1: set_mode(1'b0, 3100, 1'b1);
        2: set_mode(1'b0, 4095, 1'b1);
        default: set_mode(1'b0, $urandom_range(4095, 2000), 1'b1);
      endcase
      if (p == RAND_PHASES - 1) set_mode(1'b1, 0, 1'b1);
      set_idling(p % 4);
      for (int i = 0; i < PHASE_WORDS; i++) push_sample(pick_sample());
    end

    drain();
    repeat (80) @(posedge clk_i);
    $display("ran %0d samples: directed extremes, then %0d random phases", words_sent,
             RAND_PHASES);
    $display("raw and calibrated modes, full scales 0..4095, %0d results checked",
             words_checked);
    if (fail_count == 0 && words_pending == 0) begin
      $display("tb_battery_voltage_filter_and_gauge: PASS");
    end else begin
      $display("tb_battery_voltage_filter_and_gauge: FAIL");
    end
    $finish;
  end

endmodule
